// ===== hw/rtl/ptsort_pkg.sv =====
// Shared constants, types and controller encodings for the point sorter.
// Used by ptsort_sqrt, ptsort_dp, ptsort_ctrl and point_sort_by_origin_distance.
`default_nettype none
package ptsort_pkg;

  localparam int POINTS    = 16;
  localparam int CountW    = $clog2(POINTS + 1);
  localparam int CoordW    = 16;
  localparam int KeyW      = 32;
  localparam int RootW     = KeyW / 2;
  localparam int RootSteps = KeyW / 2;
  localparam int StepW     = $clog2(RootSteps);
  localparam int RemW      = RootW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_INSERT,
    ST_ROOT_LOAD,
    ST_ROOT_RUN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic make_key;
    logic insert;
    logic root_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic one_left;
    logic last_seen;
    logic out_free;
    logic root_done;
  } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ptsort_sqrt.sv =====
// Iterative integer square root, two key bits per cycle.
// Depends on ptsort_pkg for key and root widths.
`default_nettype none
module ptsort_sqrt (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire [ptsort_pkg::KeyW-1:0]   value,
  output logic                         done,
  output logic [ptsort_pkg::RootW-1:0] root
);
  import ptsort_pkg::*;

  logic [KeyW-1:0]  val;
  logic [RemW-1:0]  rem;
  logic [RemW+1:0]  rem_sh;
  logic [RemW+1:0]  trial;
  logic             ge;
  logic [StepW-1:0] step;
  logic             busy;

  always_comb begin
    rem_sh = {rem, val[KeyW-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == StepW'(RootSteps - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= value;
      rem  <= '0;
      root <= '0;
      step <= '0;
    end else if (busy) begin
      val  <= {val[KeyW-3:0], 2'b00};
      rem  <= ge ? RemW'(rem_sh - trial) : RemW'(rem_sh);
      root <= {root[RootW-2:0], ge};
      step <= step + StepW'(1);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ptsort_dp.sv =====
// Datapath: input capture, squared norm, sorted insertion cells, root unit, output register.
// Depends on ptsort_pkg and ptsort_sqrt.
`default_nettype none
module ptsort_dp (
  input  wire                                clk,
  input  wire                                rst,
  input  wire ptsort_pkg::cmd_t              cmd,
  output ptsort_pkg::status_t                status,
  input  wire signed [ptsort_pkg::CoordW-1:0] in_x,
  input  wire signed [ptsort_pkg::CoordW-1:0] in_y,
  input  wire                                in_last,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic signed [ptsort_pkg::CoordW-1:0] out_x,
  output logic signed [ptsort_pkg::CoordW-1:0] out_y,
  output logic [ptsort_pkg::RootW-1:0]       out_dist,
  output logic                               out_overflow,
  output logic                               out_last
);
  import ptsort_pkg::*;

  logic [CoordW-1:0] x_hold, y_hold;
  logic              last_hold;
  logic [CoordW-1:0] ax, ay;
  logic [KeyW-1:0]   sqx, sqy, key_new;

  logic [CoordW-1:0] cell_x   [POINTS];
  logic [CoordW-1:0] cell_y   [POINTS];
  logic [KeyW-1:0]   cell_key [POINTS];
  logic [CountW-1:0] count;
  logic              overflow_seen;

  logic [POINTS-1:0] gt, take_new;
  logic              root_done;
  logic [RootW-1:0]  root;

  assign ax = in_x[CoordW-1] ? (~$unsigned(in_x) + CoordW'(1)) : $unsigned(in_x);
  assign ay = in_y[CoordW-1] ? (~$unsigned(in_y) + CoordW'(1)) : $unsigned(in_y);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_hold    <= $unsigned(in_x);
      y_hold    <= $unsigned(in_y);
      last_hold <= in_last;
      sqx       <= {{(KeyW-CoordW){1'b0}}, ax} * {{(KeyW-CoordW){1'b0}}, ax};
      sqy       <= {{(KeyW-CoordW){1'b0}}, ay} * {{(KeyW-CoordW){1'b0}}, ay};
    end
    if (cmd.make_key) begin
      key_new <= sqx + sqy;
    end
  end

  // Cells at and beyond the insertion point move up one; the new point lands
  // after every cell whose key is less than or equal to its own.
  always_comb begin
    for (int i = 0; i < POINTS; i++) begin
      gt[i] = (CountW'(i) < count) && (cell_key[i] > key_new);
    end
    take_new[0] = gt[0] || (count == '0);
    for (int i = 1; i < POINTS; i++) begin
      take_new[i] = !gt[i-1] && (gt[i] || (count == CountW'(i)));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && !status.full) begin
      for (int i = 1; i < POINTS; i++) begin
        if (gt[i-1]) begin
          cell_x[i]   <= cell_x[i-1];
          cell_y[i]   <= cell_y[i-1];
          cell_key[i] <= cell_key[i-1];
        end else if (take_new[i]) begin
          cell_x[i]   <= x_hold;
          cell_y[i]   <= y_hold;
          cell_key[i] <= key_new;
        end
      end
      if (take_new[0]) begin
        cell_x[0]   <= x_hold;
        cell_y[0]   <= y_hold;
        cell_key[0] <= key_new;
      end
    end else if (cmd.emit) begin
      for (int i = 0; i < POINTS - 1; i++) begin
        cell_x[i]   <= cell_x[i+1];
        cell_y[i]   <= cell_y[i+1];
        cell_key[i] <= cell_key[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.insert) begin
      if (status.full) begin
        overflow_seen <= 1'b1;
      end else begin
        count <= count + CountW'(1);
      end
    end else if (cmd.emit) begin
      count <= count - CountW'(1);
      if (status.one_left) begin
        overflow_seen <= 1'b0;
      end
    end
  end

  ptsort_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.root_start),
    .value (cell_key[0]),
    .done  (root_done),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x        <= $signed(cell_x[0]);
      out_y        <= $signed(cell_y[0]);
      out_dist     <= root;
      out_overflow <= overflow_seen;
      out_last     <= status.one_left;
    end
  end

  always_comb begin
    status.full      = count == CountW'(POINTS);
    status.one_left  = count == CountW'(1);
    status.last_seen = last_hold;
    status.out_free  = !out_valid || !out_stall;
    status.root_done = root_done;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ptsort_ctrl.sv =====
// Controller state machine: sequences capture, insertion and the per-result root and emit.
// Depends on ptsort_pkg.
`default_nettype none
module ptsort_ctrl (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire ptsort_pkg::status_t status,
  output ptsort_pkg::cmd_t         cmd
);
  import ptsort_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SQUARE;
      end
      ST_SQUARE: state_next = ST_INSERT;
      ST_INSERT: begin
        state_next = status.last_seen ? ST_ROOT_LOAD : ST_IDLE;
      end
      ST_ROOT_LOAD: state_next = ST_ROOT_RUN;
      ST_ROOT_RUN: begin
        if (status.root_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) state_next = status.one_left ? ST_IDLE : ST_ROOT_LOAD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SQUARE:    cmd.make_key   = 1'b1;
      ST_INSERT:    cmd.insert     = 1'b1;
      ST_ROOT_LOAD: cmd.root_start = 1'b1;
      ST_ROOT_RUN:  cmd            = '0;
      ST_EMIT:      cmd.emit       = status.out_free;
      default:      cmd            = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/point_sort_by_origin_distance.sv =====
// Point sorter top level: each point passes through capture and square, sum, and insert.
// The closing point starts emission: each result then passes through root load, the
// 16-step square root unit, completion and emit, and emit waits while out_stall is held.
// Reset clears the state machine, point count, overflow flag and output valid;
// the cell contents stay undefined until written.
`default_nettype none
module point_sort_by_origin_distance (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire signed [ptsort_pkg::CoordW-1:0]  in_x,
  input  wire signed [ptsort_pkg::CoordW-1:0]  in_y,
  input  wire                                  in_last,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [ptsort_pkg::CoordW-1:0] out_x,
  output logic signed [ptsort_pkg::CoordW-1:0] out_y,
  output logic [ptsort_pkg::RootW-1:0]         out_dist,
  output logic                                 out_overflow,
  output logic                                 out_last
);
  import ptsort_pkg::*;

  // Commands flow from the controller, status back from the datapath.
  cmd_t    cmd;
  status_t status;

  // Controller: accepts one input transaction at a time, then walks the
  // sorted cells through the root unit once the set is closed.
  ptsort_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: the output register decouples result transactions, so a new
  // set can start loading while the final result still waits.
  ptsort_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_dist     (out_dist),
    .out_overflow (out_overflow),
    .out_last     (out_last)
  );

endmodule
`default_nettype wire

// ===== tb/tb_point_sort_by_origin_distance.sv =====
// Self-checking testbench for point_sort_by_origin_distance: sends point sets, predicts
// the sorted results with a cycle-free model kept here, and checks every output transaction.
// Depends on ptsort_pkg for the capacity and field widths, and on the block's RTL.
module tb_point_sort_by_origin_distance;

  localparam int CW   = ptsort_pkg::CoordW;
  localparam int RW   = ptsort_pkg::RootW;
  localparam int KW   = ptsort_pkg::KeyW;
  localparam int NPTS = ptsort_pkg::POINTS;

  // Idle odds in percent, receiver hold-off length, settle time after the
  // last result, and the hang guard.
  localparam int IDLE_PCT     = 21;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 40;
  localparam int CYCLE_LIMIT  = 300000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [RW-1:0]        distance;
    logic                 ovf;
    logic                 last;
  } sorted_point_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  wire                  in_stall;
  logic signed [CW-1:0] in_x = '0;
  logic signed [CW-1:0] in_y = '0;
  logic                 in_last = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic [RW-1:0]        out_dist;
  logic                 out_overflow;
  logic                 out_last;

  point_sort_by_origin_distance dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_dist     (out_dist),
    .out_overflow (out_overflow),
    .out_last     (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sorter image: points held in ascending norm order, like the block's cells.
  logic signed [CW-1:0] slot_x    [NPTS];
  logic signed [CW-1:0] slot_y    [NPTS];
  logic [KW-1:0]        slot_norm [NPTS];
  int                   slots_used = 0;
  bit                   dropped_in_set = 1'b0;

  // Results the block still owes, oldest first.
  sorted_point_t sorted_due[$];

  bit in_idle_en  = 1'b1;
  bit out_idle_en = 1'b1;
  int hold_seq    = 0;   // bump to ask the receiver for one long hold-off
  int hold_seen   = 0;
  int hold_left   = 0;

  int errors        = 0;
  int items_sent    = 0;
  int sets_closed   = 0;
  int overflow_sets = 0;
  int results_seen  = 0;
  int cycle_count   = 0;

  logic signed [CW-1:0] prev_x = '0;
  logic signed [CW-1:0] prev_y = '0;

  // Truncated square root, one result bit per trial from the top down.
  function automatic logic [RW-1:0] floor_root(input logic [KW-1:0] v);
    logic [RW-1:0] root;
    logic [KW-1:0] trial;
    root = '0;
    for (int b = RW - 1; b >= 0; b--) begin
      trial = KW'(root | (RW'(1) << b));
      if (trial * trial <= v)
        root = root | (RW'(1) << b);
    end
    return root;
  endfunction

  // Insert one accepted point after every stored point of equal or smaller norm;
  // on the closing transaction queue the whole sorted set and start a new one.
  task automatic sort_point(input logic signed [CW-1:0] x, y, input bit last);
    int            xi, yi, pos;
    logic [KW-1:0] ax, ay, norm;
    sorted_point_t r;
    if (slots_used < NPTS) begin
      xi = x;
      yi = y;
      ax = (xi < 0) ? -xi : xi;
      ay = (yi < 0) ? -yi : yi;
      norm = ax * ax + ay * ay;
      pos = slots_used;
      while (pos > 0 && slot_norm[pos-1] > norm) begin
        slot_x[pos]    = slot_x[pos-1];
        slot_y[pos]    = slot_y[pos-1];
        slot_norm[pos] = slot_norm[pos-1];
        pos--;
      end
      slot_x[pos]    = x;
      slot_y[pos]    = y;
      slot_norm[pos] = norm;
      slots_used++;
    end else begin
      dropped_in_set = 1'b1;
    end
    if (last) begin
      for (int k = 0; k < slots_used; k++) begin
        r.x        = slot_x[k];
        r.y        = slot_y[k];
        r.distance = floor_root(slot_norm[k]);
        r.ovf      = dropped_in_set;
        r.last     = (k == slots_used - 1);
        sorted_due.push_back(r);
      end
      if (dropped_in_set)
        overflow_sets++;
      sets_closed++;
      slots_used     = 0;
      dropped_in_set = 1'b0;
    end
  endtask

  // Offer one point; change inputs only on the falling edge and hold the payload
  // until the rising edge that accepts it.
  task automatic send_point(input logic signed [CW-1:0] x, y, input bit last);
    @(negedge clk);
    while (in_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_x     <= x;
    in_y     <= y;
    in_last  <= last;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    items_sent++;
    sort_point(x, y, last);
  endtask

  // Drop valid, then hold off until every owed result has come back.
  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sorted_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] extreme_coord();
    case ($urandom_range(0, 4))
      0:       return CW'(-32768);
      1:       return CW'(32767);
      2:       return CW'(0);
      3:       return CW'(-1);
      default: return CW'(1);
    endcase
  endfunction

  // Mix full-range coordinates with small values, extremes, and mirrors of the
  // previous point (same norm, different coordinates) to exercise tie ordering.
  task automatic pick_point(output logic signed [CW-1:0] x, y);
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      x = CW'($urandom);
      y = CW'($urandom);
    end else if (kind < 65) begin
      x = CW'(int'($urandom_range(0, 16)) - 8);
      y = CW'(int'($urandom_range(0, 16)) - 8);
    end else if (kind < 80) begin
      x = extreme_coord();
      y = extreme_coord();
    end else if ($urandom_range(0, 1) == 0) begin
      x = -prev_x;
      y = prev_y;
    end else begin
      x = prev_y;
      y = -prev_x;
    end
    prev_x = x;
    prev_y = y;
  endtask

  task automatic send_random_set(input int count);
    logic signed [CW-1:0] x, y;
    for (int i = 0; i < count; i++) begin
      pick_point(x, y);
      send_point(x, y, i == count - 1);
    end
  endtask

  // Mostly sets that fit, some tiny ones, and now and then an overfull set.
  function automatic int pick_set_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)
      return $urandom_range(NPTS + 1, NPTS + 4);
    else if (r < 25)
      return $urandom_range(1, 2);
    else
      return $urandom_range(3, NPTS);
  endfunction

  // Single-point sets at the corners of the coordinate range and at the origin.
  task automatic test_single_extremes();
    send_point(CW'(-32768), CW'(-32768), 1'b1);
    send_point(CW'(0), CW'(0), 1'b1);
    send_point(CW'(32767), CW'(32767), 1'b1);
    wait_all_results();
  endtask

  // The tied pair (1,-1), (-1,1) must come out in arrival order, among extreme points of mixed signs.
  task automatic test_ties_and_signs();
    send_point(CW'(32767), CW'(0), 1'b0);
    send_point(CW'(0), CW'(-32768), 1'b0);
    send_point(CW'(1), CW'(-1), 1'b0);
    send_point(CW'(-1), CW'(1), 1'b0);
    send_point(CW'(-32768), CW'(32767), 1'b1);
    wait_all_results();
  endtask

  // Fill capacity with descending norms (each insert shifts the whole store),
  // then close the set with a point that is dropped.
  task automatic test_capacity_drop();
    for (int i = 0; i < NPTS; i++)
      send_point(CW'((NPTS - i) * 256), CW'(-(NPTS - i) * 16), 1'b0);
    send_point(CW'(0), CW'(0), 1'b1);
    wait_all_results();
  endtask

  task automatic test_random_sets(input int target);
    int start;
    start = items_sent;
    while (items_sent - start < target)
      send_random_set(pick_set_size());
    wait_all_results();
  endtask

  // Long stretch with no idling on either side.
  task automatic test_back_to_back(input int target);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    test_random_sets(target);
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  // Hold the receiver off while a full set and then another set are offered, so
  // the block backs up and stalls its input.
  task automatic test_stall_fill();
    hold_seq++;
    send_random_set(NPTS);
    send_random_set(10);
    wait_all_results();
  endtask

  // Receiver: honor a hold-off request first, else stall at random.
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= out_idle_en && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Compare each accepted output transaction with the oldest owed result.
  always @(posedge clk) begin : check_out
    sorted_point_t want;
    if (!rst && out_valid && !out_stall) begin
      if (sorted_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual x=%0d y=%0d dist=%0d",
                 $time, out_x, out_y, out_dist);
      end else begin
        want = sorted_due.pop_front();
        results_seen++;
        check_field("out_x", int'(want.x), int'(out_x));
        check_field("out_y", int'(want.y), int'(out_y));
        check_field("out_dist", int'(want.distance), int'(out_dist));
        check_field("out_overflow", int'(want.ovf), int'(out_overflow));
        check_field("out_last", int'(want.last), int'(out_last));
      end
    end
  end

  // Hang guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still owed", $time, sorted_due.size());
      $display("FAIL point_sort_by_origin_distance");
      $finish;
    end
  end

  initial begin
    // Hold reset, then release it on a falling edge.
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_single_extremes();
    test_ties_and_signs();
    test_capacity_drop();
    test_random_sets(300);
    test_back_to_back(80);
    test_stall_fill();

    if (sorted_due.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, sorted_due.size());
    end
    $display("Covered %0d sets (%0d with dropped points) from %0d points;", sets_closed,
             overflow_sets, items_sent);
    $display("checked %0d sorted results against the prediction, %0d errors.", results_seen,
             errors);
    if (errors == 0) begin
      $display("PASS point_sort_by_origin_distance");
    end else begin
      $display("FAIL point_sort_by_origin_distance");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ptsort_pkg.sv
hw/rtl/ptsort_sqrt.sv
hw/rtl/ptsort_dp.sv
hw/rtl/ptsort_ctrl.sv
hw/rtl/point_sort_by_origin_distance.sv
tb/tb_point_sort_by_origin_distance.sv
